// ----- design/firfc_pkg.sv -----
// ----------------------------------------------------------------------------
// firfc_pkg
// Shared types and constants of the FIR convolution block: field widths,
// command codes and the command/status structs between control and datapath.
// ----------------------------------------------------------------------------
package firfc_pkg;

    // default filter length
    localparam int TAPS_DEF = 64;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 6;

    // command codes of an input word
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic wr_coef;
        logic wr_sample;
        logic wr_zero;
        logic clr_line;
        logic issue;
        logic clr_acc;
        logic load_out;
        logic out_last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic busy;
    } t_dp_sts;

endpackage

// ----- design/firfc_if.sv -----
// ----------------------------------------------------------------------------
// firfc_if
// Valid/ready channels of the FIR convolution block: input words and
// result words.
// ----------------------------------------------------------------------------
interface firfc_in_if;
    logic                valid;
    logic                ready;
    logic                command;
    logic signed [15:0]  sample;
    logic                last_sample;
    logic        [5:0]   coeff_index;
    logic signed [15:0]  coeff_value;

    modport source (output valid, command, sample, last_sample, coeff_index, coeff_value,
                    input ready);
    modport sink   (input valid, command, sample, last_sample, coeff_index, coeff_value,
                    output ready);
endinterface

interface firfc_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  filtered;
    logic                last_output;
    logic                saturated;

    modport source (output valid, filtered, last_output, saturated, input ready);
    modport sink   (input valid, filtered, last_output, saturated, output ready);
endinterface

// ----- design/firfc_dp.sv -----
// ----------------------------------------------------------------------------
// firfc_dp
// Datapath: coefficient memory, circular delay-line memory, a registered
// multiply-accumulate pipeline, and the rounding/saturating output register.
// ----------------------------------------------------------------------------
module firfc_dp import firfc_pkg::*; #(
    parameter  int TAPS = TAPS_DEF,
    localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1,
    localparam int ACCW = 33 + $clog2(TAPS),
    localparam int QW   = ACCW - 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic        [AW-1:0]       i_rd_k,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [IDX_W-1:0]    i_coeff_index,
    input  logic signed [SAMPLE_W-1:0] i_coeff_value,
    output t_dp_sts                    o_sts,
    output logic signed [SAMPLE_W-1:0] o_filtered,
    output logic                       o_last_output,
    output logic                       o_saturated
);

    localparam logic signed [QW-1:0] QMAX = QW'(32767);
    localparam logic signed [QW-1:0] QMIN = -QW'(32768);

    // memories and their valid bits
    logic signed [SAMPLE_W-1:0] r_coef_mem [TAPS];
    logic signed [SAMPLE_W-1:0] r_line_mem [TAPS];
    logic        [TAPS-1:0]     r_coef_vld;
    logic        [TAPS-1:0]     r_line_vld;
    logic        [AW-1:0]       r_wp;

    // pipeline registers
    logic signed [SAMPLE_W-1:0] r_c_rd, r_d_rd;
    logic                       r_c_ok, r_d_ok;
    logic                       r_p1, r_p2;
    logic signed [31:0]         r_prod;
    logic signed [ACCW-1:0]     r_acc;
    logic signed [SAMPLE_W-1:0] r_filt;
    logic                       r_last, r_sat;

    logic        [AW-1:0]       wp_dec;
    logic        [AW:0]         rd_sum;
    logic        [AW-1:0]       rd_addr;
    logic                       idx_ok;
    logic        [AW-1:0]       coef_addr;
    logic                       line_wr;
    logic signed [SAMPLE_W-1:0] line_data;
    logic signed [SAMPLE_W-1:0] op_c, op_d;
    logic signed [ACCW-1:0]     acc_rnd;
    logic signed [QW-1:0]       q;

    // address arithmetic: newest sample sits at the write pointer
    assign wp_dec    = (r_wp == '0) ? AW'(TAPS - 1) : r_wp - 1'b1;
    assign rd_sum    = {1'b0, r_wp} + {1'b0, i_rd_k};
    assign rd_addr   = (rd_sum >= (AW+1)'(TAPS)) ? AW'(rd_sum - (AW+1)'(TAPS)) : AW'(rd_sum);
    assign idx_ok    = (IDX_W+1)'(i_coeff_index) < (IDX_W+1)'(TAPS);
    assign coef_addr = AW'(i_coeff_index);
    assign line_wr   = i_cmd.wr_sample | i_cmd.wr_zero;
    assign line_data = i_cmd.wr_zero ? '0 : i_sample;

    // coefficient memory write
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coef && idx_ok) begin
            r_coef_mem[coef_addr] <= i_coeff_value;
        end
    end

    // delay line memory write
    always_ff @(posedge i_clk) begin
        if (line_wr) begin
            r_line_mem[wp_dec] <= line_data;
        end
    end

    // registered reads of both memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_c_rd <= r_coef_mem[i_rd_k];
            r_d_rd <= r_line_mem[rd_addr];
            r_c_ok <= r_coef_vld[i_rd_k];
            r_d_ok <= r_line_vld[rd_addr];
        end
    end

    // valid bits, write pointer and pipeline flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
            r_line_vld <= '0;
            r_wp       <= '0;
            r_p1       <= 1'b0;
            r_p2       <= 1'b0;
        end else begin
            r_p1 <= i_cmd.issue;
            r_p2 <= r_p1;
            if (i_cmd.wr_coef && idx_ok) begin
                r_coef_vld[coef_addr] <= 1'b1;
            end
            if (i_cmd.clr_line) begin
                r_line_vld <= '0;
            end else if (line_wr) begin
                r_line_vld[wp_dec] <= 1'b1;
            end
            if (line_wr) begin
                r_wp <= wp_dec;
            end
        end
    end

    // multiply stage
    assign op_c = r_c_ok ? r_c_rd : '0;
    assign op_d = r_d_ok ? r_d_rd : '0;

    always_ff @(posedge i_clk) begin
        if (r_p1) begin
            r_prod <= op_c * op_d;
        end
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (r_p2) begin
            r_acc <= r_acc + ACCW'(r_prod);
        end
    end

    // round half up to Q1.15, then saturate
    assign acc_rnd = r_acc + ACCW'(16384);
    assign q       = QW'(acc_rnd >>> 15);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_last <= i_cmd.out_last;
            if (q > QMAX) begin
                r_filt <= 16'sh7fff;
                r_sat  <= 1'b1;
            end else if (q < QMIN) begin
                r_filt <= -16'sh8000;
                r_sat  <= 1'b1;
            end else begin
                r_filt <= SAMPLE_W'(q);
                r_sat  <= 1'b0;
            end
        end
    end

    assign o_sts.busy    = r_p1 | r_p2;
    assign o_filtered    = r_filt;
    assign o_last_output = r_last;
    assign o_saturated   = r_sat;

endmodule

// ----- design/firfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// firfc_ctrl
// Controller: holds the length register, sequences one multiply-accumulate
// pass per output word, runs the tail flush and owns the result valid flag.
// ----------------------------------------------------------------------------
module firfc_ctrl import firfc_pkg::*; #(
    parameter  int TAPS = TAPS_DEF,
    localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1,
    localparam int NW   = $clog2(TAPS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_command,
    input  logic             i_last_sample,
    input  logic             i_out_ready,
    input  t_dp_sts          i_sts,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output t_dp_cmd          o_cmd,
    output logic [AW-1:0]    o_rd_k
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_k, n_k;
    logic [NW-1:0]    r_n, n_n;
    logic [NW-1:0]    r_rem, n_rem;
    logic             r_blk, n_blk;
    logic             r_ovld, n_ovld;
    logic [CNT_W-1:0] r_tap;
    logic [NW-1:0]    n_use;
    logic             in_acc;
    logic             slot_free;

    // length in use: zero acts as one, above TAPS acts as TAPS
    always_comb begin
        if (r_tap == '0) begin
            n_use = NW'(1);
        end else if (r_tap > CNT_W'(TAPS)) begin
            n_use = NW'(TAPS);
        end else begin
            n_use = NW'(r_tap);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_ovld || i_out_ready;

    // next-state logic
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_n     = r_n;
        n_rem   = r_rem;
        n_blk   = r_blk;
        n_ovld  = r_ovld && !i_out_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.wr_coef = 1'b1;
                    end else begin
                        o_cmd.wr_sample = 1'b1;
                        o_cmd.clr_acc   = 1'b1;
                        n_n     = n_use;
                        n_rem   = i_last_sample ? n_use - 1'b1 : '0;
                        n_blk   = i_last_sample;
                        n_k     = '0;
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                if ((NW+1)'(r_k) + (NW+1)'(1) == (NW+1)'(r_n)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_last = r_blk && (r_rem == '0);
                    n_ovld = 1'b1;
                    if (r_rem != '0) begin
                        // tail flush: shift in a zero and run another pass
                        o_cmd.wr_zero = 1'b1;
                        o_cmd.clr_acc = 1'b1;
                        n_rem   = r_rem - 1'b1;
                        n_k     = '0;
                        n_state = S_MAC;
                    end else begin
                        o_cmd.clr_line = r_blk;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_n     <= NW'(1);
            r_rem   <= '0;
            r_blk   <= 1'b0;
            r_ovld  <= 1'b0;
            r_tap   <= CNT_W'(TAPS);
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_n     <= n_n;
            r_rem   <= n_rem;
            r_blk   <= n_blk;
            r_ovld  <= n_ovld;
            if (i_cfg_we) begin
                r_tap <= i_cfg_wdata;
            end
        end
    end

    assign o_out_valid = r_ovld;
    assign o_rd_k      = r_k;

endmodule

// ----- design/fir_full_convolution.sv -----
// ----------------------------------------------------------------------------
// fir_full_convolution
// FIR filter by direct convolution with tail flush, Q1.15 in and out.
// ----------------------------------------------------------------------------
// A load word writes one coefficient and gives no result. A sample word
// gives one output word, n being the length in use (tap_count clipped to
// 1..TAPS): one shared multiply-accumulate unit reads one coefficient and
// one delay-line entry per cycle from their memories, the read, multiply
// and accumulate stages are registered, and the sum is then rounded into
// the output register. A sample marked last is followed by n-1 tail
// outputs, each from its own pass, the final one marked; the delay line is
// then cleared at once. A new word is taken while the previous output waits
// in the output register.
module fir_full_convolution import firfc_pkg::*; #(
    parameter int TAPS = TAPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    firfc_in_if.sink         i_in,
    firfc_out_if.source      o_out
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [AW-1:0] rd_k;

    // controller
    firfc_ctrl #(.TAPS(TAPS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in.valid),
        .i_command     (i_in.command),
        .i_last_sample (i_in.last_sample),
        .i_out_ready   (o_out.ready),
        .i_sts         (sts),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .o_cmd         (cmd),
        .o_rd_k        (rd_k)
    );

    // datapath
    firfc_dp #(.TAPS(TAPS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rd_k        (rd_k),
        .i_sample      (i_in.sample),
        .i_coeff_index (i_in.coeff_index),
        .i_coeff_value (i_in.coeff_value),
        .o_sts         (sts),
        .o_filtered    (o_out.filtered),
        .o_last_output (o_out.last_output),
        .o_saturated   (o_out.saturated)
    );

    // no word taken while the multiply-accumulate pipeline still holds data
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !sts.busy)
        else $error("input word taken while pipeline busy");

    // an output load never overwrites a result that was not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out.valid || o_out.ready))
        else $error("result overwritten before it was taken");

    // the output register is loaded only after the pipeline has drained
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!sts.busy && !cmd.issue))
        else $error("output loaded while accumulation in flight");

endmodule
